// ===== hdl/tli_pkg.sv =====
// Package for the table linear interpolator.
// Holds table sizes, field widths, command and status codes and sequencer states.
// No dependencies.
package tli_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ENTRY_AW    = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = 7;
    localparam int FREQ_W      = 24;
    localparam int GAIN_W      = 32;
    localparam int DG_W        = GAIN_W + 1;
    localparam int PROD_W      = DG_W + FREQ_W + 1;
    localparam int QUO_W       = DG_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int DCNT_W      = $clog2(DIV_STEPS);
    localparam int SUM_W       = GAIN_W + 3;

    localparam logic [SUM_W-1:0] GAIN_MAX = SUM_W'((64'sd1 <<< (GAIN_W - 1)) - 1);
    localparam logic [SUM_W-1:0] GAIN_MIN = SUM_W'(-(64'sd1 <<< (GAIN_W - 1)));

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_INTERP = 2'd0,
        ST_BELOW  = 2'd1,
        ST_ABOVE  = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK0,
        S_CHKN,
        S_SRCH,
        S_DIFF,
        S_MUL,
        S_DINI,
        S_DIV,
        S_ADD,
        S_FIN
    } t_state;

endpackage

// ===== hdl/table_linear_interpolator.sv =====
// Table linear interpolator: point table, linear search and serial divider.
// Depends on tli_pkg.
//
// Usage:
// - Input channel (i_in_valid / o_in_stall) takes one word per item. A write
//   word (command 0) stores a frequency/gain point in one slot and gives no
//   result. A query word (command 1) gives one result word on the output
//   channel (o_out_valid / i_out_stall): gain and a status code.
// - entry_count (APB, byte address 0) sets how many points are in use.
//   Write it only while the block is idle.
// - A query on an empty table goes straight to its result; otherwise it checks
//   the first point (clamp below), then the last point (clamp above), and
//   else interpolates after a linear search that passes up to 62 points
//   (one table read per cycle) and a 33-step restoring divider. The block
//   takes no new word while a query is in flight.
// - A finished result sits in an output register; the block accepts new
//   words while it waits. A query that finishes while the old result is
//   still stalled holds until the receiver takes it.
// - Reset clears the sequencer, output valid and entry_count. Table contents
//   are undefined until written.
module table_linear_interpolator
    import tli_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_command,
    input  logic [5:0]                i_entry_index,
    input  logic [FREQ_W-1:0]         i_entry_freq,
    input  logic signed [GAIN_W-1:0]  i_entry_gain,
    input  logic [FREQ_W-1:0]         i_query_freq,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [GAIN_W-1:0]  o_gain_out,
    output logic [1:0]                o_status
);

    logic [FREQ_W-1:0]        r_freq_mem [TABLE_DEPTH];
    logic [GAIN_W-1:0]        r_gain_mem [TABLE_DEPTH];
    logic [FREQ_W-1:0]        r_rd_freq;
    logic [GAIN_W-1:0]        r_rd_gain;

    logic [COUNT_W-1:0]       r_count;
    t_state                   r_state, n_state;
    logic [FREQ_W-1:0]        r_q, n_q;
    logic [ENTRY_AW-1:0]      r_last, n_last;
    logic [ENTRY_AW-1:0]      r_j, n_j;
    logic [FREQ_W-1:0]        r_prev_f, n_prev_f;
    logic [GAIN_W-1:0]        r_prev_g, n_prev_g;
    logic [FREQ_W-1:0]        r_cur_f, n_cur_f;
    logic [GAIN_W-1:0]        r_cur_g, n_cur_g;
    logic signed [DG_W-1:0]   r_dg, n_dg;
    logic [FREQ_W-1:0]        r_dq, n_dq;
    logic [FREQ_W-1:0]        r_df, n_df;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic                     r_neg, n_neg;
    logic [FREQ_W-1:0]        r_rem, n_rem;
    logic [QUO_W-1:0]         r_quo, n_quo;
    logic [DCNT_W-1:0]        r_cnt, n_cnt;
    logic [GAIN_W-1:0]        r_res_gain, n_res_gain;
    t_status                  r_res_status, n_res_status;
    logic                     r_out_vld, n_out_vld;
    logic [GAIN_W-1:0]        r_out_gain, n_out_gain;
    t_status                  r_out_status, n_out_status;

    logic                     w_accept;
    logic                     w_wr;
    logic [ENTRY_AW-1:0]      w_rd_addr;
    logic [COUNT_W-1:0]       w_n;
    logic [PROD_W-1:0]        w_mag;
    logic [FREQ_W:0]          w_rem_sh;
    logic [FREQ_W:0]          w_trial;
    logic signed [QUO_W:0]    w_sq;
    logic signed [SUM_W-1:0]  w_sum;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? {{(32-COUNT_W){1'b0}}, r_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRY_COUNT) begin
            r_count <= pwdata[COUNT_W-1:0];
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_wr       = w_accept && i_command == CMD_WRITE;
    assign w_n        = (r_count > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : r_count;

    // Point table
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_freq_mem[i_entry_index[ENTRY_AW-1:0]] <= i_entry_freq;
            r_gain_mem[i_entry_index[ENTRY_AW-1:0]] <= i_entry_gain;
        end
        r_rd_freq <= r_freq_mem[w_rd_addr];
        r_rd_gain <= r_gain_mem[w_rd_addr];
    end

    assign w_mag    = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign w_rem_sh = {r_rem, r_quo[QUO_W-1]};
    assign w_trial  = w_rem_sh - {1'b0, r_df};
    assign w_sq     = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_sum    = SUM_W'($signed(r_prev_g)) + SUM_W'(w_sq);

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_q          = r_q;
        n_last       = r_last;
        n_j          = r_j;
        n_prev_f     = r_prev_f;
        n_prev_g     = r_prev_g;
        n_cur_f      = r_cur_f;
        n_cur_g      = r_cur_g;
        n_dg         = r_dg;
        n_dq         = r_dq;
        n_df         = r_df;
        n_prod       = r_prod;
        n_neg        = r_neg;
        n_rem        = r_rem;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_res_gain   = r_res_gain;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld && i_out_stall;
        n_out_gain   = r_out_gain;
        n_out_status = r_out_status;
        w_rd_addr    = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept && i_command == CMD_QUERY) begin
                    n_q    = i_query_freq;
                    n_last = ENTRY_AW'(w_n - COUNT_W'(1));
                    if (r_count == '0) begin
                        n_res_gain   = '0;
                        n_res_status = ST_EMPTY;
                        n_state      = S_FIN;
                    end else begin
                        n_state = S_CHK0;
                    end
                end
            end
            S_CHK0: begin
                if (r_q < r_rd_freq) begin
                    n_res_gain   = r_rd_gain;
                    n_res_status = ST_BELOW;
                    n_state      = S_FIN;
                end else begin
                    n_prev_f  = r_rd_freq;
                    n_prev_g  = r_rd_gain;
                    w_rd_addr = r_last;
                    n_state   = S_CHKN;
                end
            end
            S_CHKN: begin
                if (r_q >= r_rd_freq) begin
                    n_res_gain   = r_rd_gain;
                    n_res_status = ST_ABOVE;
                    n_state      = S_FIN;
                end else begin
                    n_j       = ENTRY_AW'(1);
                    w_rd_addr = ENTRY_AW'(1);
                    n_state   = S_SRCH;
                end
            end
            S_SRCH: begin
                if (r_j < r_last && r_rd_freq <= r_q) begin
                    n_prev_f  = r_rd_freq;
                    n_prev_g  = r_rd_gain;
                    n_j       = r_j + ENTRY_AW'(1);
                    w_rd_addr = r_j + ENTRY_AW'(1);
                end else begin
                    n_cur_f = r_rd_freq;
                    n_cur_g = r_rd_gain;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_dg    = DG_W'($signed(r_cur_g)) - DG_W'($signed(r_prev_g));
                n_dq    = r_q - r_prev_f;
                n_df    = r_cur_f - r_prev_f;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_dg * $signed({1'b0, r_dq}));
                n_state = S_DINI;
            end
            S_DINI: begin
                n_neg   = r_prod[PROD_W-1];
                n_rem   = w_mag[QUO_W +: FREQ_W];
                n_quo   = w_mag[QUO_W-1:0];
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!w_trial[FREQ_W]) begin
                    n_rem = w_trial[FREQ_W-1:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = w_rem_sh[FREQ_W-1:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + DCNT_W'(1);
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                if ($signed(w_sum) > $signed(GAIN_MAX)) begin
                    n_res_gain = GAIN_MAX[GAIN_W-1:0];
                end else if ($signed(w_sum) < $signed(GAIN_MIN)) begin
                    n_res_gain = GAIN_MIN[GAIN_W-1:0];
                end else begin
                    n_res_gain = w_sum[GAIN_W-1:0];
                end
                n_res_status = ST_INTERP;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld    = 1'b1;
                    n_out_gain   = r_res_gain;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q          <= n_q;
        r_last       <= n_last;
        r_j          <= n_j;
        r_prev_f     <= n_prev_f;
        r_prev_g     <= n_prev_g;
        r_cur_f      <= n_cur_f;
        r_cur_g      <= n_cur_g;
        r_dg         <= n_dg;
        r_dq         <= n_dq;
        r_df         <= n_df;
        r_prod       <= n_prod;
        r_neg        <= n_neg;
        r_rem        <= n_rem;
        r_quo        <= n_quo;
        r_cnt        <= n_cnt;
        r_res_gain   <= n_res_gain;
        r_res_status <= n_res_status;
        r_out_gain   <= n_out_gain;
        r_out_status <= n_out_status;
    end

    assign o_out_valid = r_out_vld;
    assign o_gain_out  = r_out_gain;
    assign o_status    = r_out_status;

`ifndef SYNTHESIS
    a_write_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_command == CMD_WRITE) |=> r_state == S_IDLE)
        else $error("write word started a query sequence");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> r_rem < r_df)
        else $error("divider remainder not below divisor");

    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_j <= r_last && r_j != '0))
        else $error("search index out of range");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> o_gain_out == '0)
        else $error("empty table result with nonzero gain");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for table_linear_interpolator.
// Uses tli_pkg for widths and codes. A scoreboard class predicts the gain and status
// of every query, and plain tasks drive the word channel and the APB port.
`timescale 1ns / 100ps

module tb_top
    import tli_pkg::*;
;

    localparam int          CYCLE_LIMIT      = 1_000_000;
    localparam int          QUIET_CYCLES     = 120;
    localparam int          WORD_TARGET      = 1425;
    localparam int          IDLE_OFF_AFTER   = 1250;
    localparam logic [2:0]  ADDR_ENTRY_COUNT = 3'(4 * REG_ENTRY_COUNT);
    localparam logic [2:0]  ADDR_SPARE       = 3'd4;

    typedef struct {
        logic signed [GAIN_W-1:0] gain;
        t_status                  status;
    } t_gain_result;

    class gain_scoreboard;
        logic [FREQ_W-1:0]        freq_tab [TABLE_DEPTH];
        logic signed [GAIN_W-1:0] gain_tab [TABLE_DEPTH];
        logic [COUNT_W-1:0]       entry_count = '0;
        t_gain_result             pending_gains [$];
        int                       fails = 0;

        task report(input string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            fails++;
        endtask

        function int active_points();
            return (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        endfunction

        function int pending();
            return pending_gains.size();
        endfunction

        function void set_count(input logic [COUNT_W-1:0] value);
            entry_count = value;
        endfunction

        function void note_word(input logic cmd, input logic [5:0] idx,
                                input logic [FREQ_W-1:0] f, input logic signed [GAIN_W-1:0] g,
                                input logic [FREQ_W-1:0] q);
            int           n;
            int           j;
            longint       dg;
            longint       dq;
            longint       df;
            longint       sum;
            t_gain_result r;
            if (cmd == CMD_WRITE) begin
                if (int'(idx) < TABLE_DEPTH) begin
                    freq_tab[idx] = f;
                    gain_tab[idx] = g;
                end
                return;
            end
            n = active_points();
            if (n == 0) begin
                r.gain   = '0;
                r.status = ST_EMPTY;
            end else if (q < freq_tab[0]) begin
                r.gain   = gain_tab[0];
                r.status = ST_BELOW;
            end else if (q >= freq_tab[n-1]) begin
                r.gain   = gain_tab[n-1];
                r.status = ST_ABOVE;
            end else begin
                j = 1;
                while (j < n - 1 && freq_tab[j] <= q) j++;
                dg = longint'(gain_tab[j]) - longint'(gain_tab[j-1]);
                dq = longint'(q) - longint'(freq_tab[j-1]);
                df = longint'(freq_tab[j]) - longint'(freq_tab[j-1]);
                if (df <= 0) df = 1;
                sum = longint'(gain_tab[j-1]) + (dg * dq) / df;
                if (sum > 64'sd2147483647) sum = 64'sd2147483647;
                if (sum < -64'sd2147483648) sum = -64'sd2147483648;
                r.gain   = GAIN_W'(sum);
                r.status = ST_INTERP;
            end
            pending_gains.push_back(r);
        endfunction

        task check_result(input logic signed [GAIN_W-1:0] gain, input logic [1:0] status);
            t_gain_result r;
            if (pending_gains.size() == 0) begin
                report($sformatf("result word with none expected: gain %h status %0d",
                                 gain, status));
                return;
            end
            r = pending_gains.pop_front();
            if (gain !== r.gain)
                report($sformatf("gain_out %h, expected %h", gain, r.gain));
            if (status !== r.status)
                report($sformatf("status %0d, expected %0d", status, r.status));
        endtask
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [2:0]                paddr;
    logic [31:0]               pwdata;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic                      i_command;
    logic [5:0]                i_entry_index;
    logic [FREQ_W-1:0]         i_entry_freq;
    logic signed [GAIN_W-1:0]  i_entry_gain;
    logic [FREQ_W-1:0]         i_query_freq;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [GAIN_W-1:0]  o_gain_out;
    logic [1:0]                o_status;

    gain_scoreboard sb;
    bit             idle_on = 1'b1;
    int             words_sent = 0;
    int             stall_left = 0;
    int             cycle_count = 0;

    table_linear_interpolator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_entry_index (i_entry_index),
        .i_entry_freq  (i_entry_freq),
        .i_entry_gain  (i_entry_gain),
        .i_query_freq  (i_query_freq),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_gain_out    (o_gain_out),
        .o_status      (o_status)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_gain_out, o_status);
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 14);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_word(input logic cmd, input logic [5:0] idx,
                             input logic [FREQ_W-1:0] f, input logic [GAIN_W-1:0] g,
                             input logic [FREQ_W-1:0] q);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_entry_index <= idx;
        i_entry_freq  <= f;
        i_entry_gain  <= g;
        i_query_freq  <= q;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_word(cmd, idx, f, g, q);
        words_sent++;
    endtask

    // hold off until every result is in and the block has gone quiet
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_ENTRY_COUNT)
            sb.set_count(data[COUNT_W-1:0]);
    endtask

    initial begin
        int                first_phase;
        int                n;
        int                k;
        int                fq;
        int                step_max;
        int                lo;
        int                hi;
        int                phase_words;
        logic [FREQ_W-1:0] q;

        sb = new();
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        i_in_valid    <= 1'b0;
        i_command     <= CMD_WRITE;
        i_entry_index <= '0;
        i_entry_freq  <= '0;
        i_entry_gain  <= '0;
        i_query_freq  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, spare address ignored
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd0);
        send_word(CMD_QUERY, 6'd63, 24'hFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF);
        drain_results();
        apb_write(ADDR_SPARE, 32'd2);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd5);
        send_word(CMD_WRITE, 6'd0, 24'd100, 32'h80000000, 24'd0);
        send_word(CMD_WRITE, 6'd1, 24'hFFFFFF, 32'h7FFFFFFF, 24'hFFFFFF);
        send_word(CMD_WRITE, 6'd63, 24'hFFFFFF, 32'hFFFFFFFF, 24'h000000);
        drain_results();

        // single point always clamps
        apb_write(ADDR_ENTRY_COUNT, 32'd1);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd99);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd100);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'hFFFFFF);
        drain_results();

        apb_write(ADDR_ENTRY_COUNT, 32'd2);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd0);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd100);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'h800000);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'hFFFFFE);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'hFFFFFF);
        // negative slope truncates toward zero
        send_word(CMD_WRITE, 6'd0, 24'd0, 32'd10, '0);
        send_word(CMD_WRITE, 6'd1, 24'd3, 32'd0, '0);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd1);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd2);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd0);
        send_word(CMD_WRITE, 6'd0, 24'd0, 32'h7FFFFFFF, '0);
        send_word(CMD_WRITE, 6'd1, 24'hFFFFFF, 32'h80000000, '0);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'd1);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'h7FFFFF);
        send_word(CMD_QUERY, 6'd0, '0, '0, 24'hFFFFFE);

        first_phase = 1;
        while (words_sent < WORD_TARGET) begin
            drain_results();
            case ($urandom_range(0, 9))
                0:       k = 0;
                1:       k = 1;
                2:       k = 2;
                3:       k = TABLE_DEPTH;
                4:       k = $urandom_range(TABLE_DEPTH + 1, 127);
                default: k = $urandom_range(2, TABLE_DEPTH);
            endcase
            if (first_phase) k = TABLE_DEPTH;
            apb_write(ADDR_ENTRY_COUNT, 32'(k));
            n = sb.active_points();

            // load ascending points so the search walks the whole table
            if (first_phase || $urandom_range(0, 1) == 0) begin
                lo       = first_phase ? TABLE_DEPTH : ((n < 2) ? 2 : n);
                step_max = ($urandom_range(0, 3) == 0) ? 3 : (24'hFFFFFF / lo);
                fq       = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 1000);
                for (k = 0; k < lo; k++) begin
                    send_word(CMD_WRITE, 6'(k), 24'(fq), $urandom, 24'($urandom));
                    fq += $urandom_range(0, step_max);
                    if (fq > 24'hFFFFFF) fq = 24'hFFFFFF;
                end
            end
            first_phase = 0;

            phase_words = $urandom_range(40, 100);
            repeat (phase_words) begin
                idle_on = (words_sent < IDLE_OFF_AFTER);
                if ($urandom_range(0, 99) < 15) begin
                    send_word(CMD_WRITE, 6'($urandom_range(0, 63)), 24'($urandom), $urandom,
                              24'($urandom));
                end else begin
                    q = 24'($urandom);
                    if (n > 0) begin
                        k  = $urandom_range(0, n - 1);
                        lo = int'(sb.freq_tab[0]);
                        hi = int'(sb.freq_tab[n-1]);
                        if (lo > hi) begin
                            fq = lo;
                            lo = hi;
                            hi = fq;
                        end
                        case ($urandom_range(0, 7))
                            0:       q = sb.freq_tab[k];
                            1:       q = sb.freq_tab[k] + 24'd1;
                            2:       q = sb.freq_tab[k] - 24'd1;
                            3:       q = 24'($urandom);
                            default: q = 24'(lo + $urandom_range(0, hi - lo));
                        endcase
                    end
                    send_word(CMD_QUERY, 6'($urandom_range(0, 63)), 24'($urandom), $urandom,
                              q);
                end
            end
        end

        idle_on = 1'b0;
        drain_results();
        if (sb.fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/tli_pkg.sv
hdl/table_linear_interpolator.sv
tb/tb_top.sv
